@@ sv/lsba_pkg.sv @@
// Shared types and constants for the limb-serial bignum ALU.
package lsba_pkg;

  localparam int unsigned LimbW = 64;
  localparam int unsigned HalfW = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_CMP = 2'd3
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [LimbW-1:0] limb_a;
    logic [LimbW-1:0] limb_b;
    logic             last_limb;
  } in_t;

  typedef struct packed {
    logic [LimbW-1:0] result_limb;
    logic             end_of_number;
    logic             greater_or_equal;
    logic             underflow;
  } out_t;

endpackage

@@ sv/limb_serial_bignum_alu_unit.sv @@
// Top level: limb-serial add, subtract, scalar multiply and compare on 64-bit limbs.
// Pipeline: input, partial-product and product registers, then a 4-entry result queue.
// Throughput: one limb per cycle while the input is not stalled; the carry loop closes
// in the last stage with a 64-bit add and increment.
// Input stalls while a limb waits in the last stage and the queue has under two free entries.
// Reset clears pipeline valids, the queue, the carry to zero and the verdict to one.
module limb_serial_bignum_alu_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lsba_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lsba_pkg::out_t out_data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned W     = lsba_pkg::LimbW;
  localparam int unsigned H     = lsba_pkg::HalfW;

  // stage 1: input register
  logic          v1_q;
  lsba_pkg::in_t s1_q;
  // stage 2: partial products
  logic          v2_q;
  lsba_pkg::in_t s2_q;
  logic [W-1:0]  pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  // stage 3: full product
  logic          v3_q;
  lsba_pkg::in_t s3_q;
  logic [2*W-1:0] prod_q, prod_d;

  logic [W-1:0] rc_q, rc_d;
  logic         ver_q, ver_d;

  lsba_pkg::out_t fifo_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic room, adv, commit, pop, two;
  logic [1:0] n_wr;
  lsba_pkg::out_t r0, r1;

  assign room       = cnt_q <= CntW'(Depth - 2);
  assign adv        = !v3_q || room;
  assign commit     = v3_q && room;
  assign in_stall_o = !adv;
  assign pop        = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = fifo_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= in_data_i;
      s2_q    <= s1_q;
      pp_ll_q <= W'(s1_q.limb_a[H-1:0]) * W'(s1_q.limb_b[H-1:0]);
      pp_lh_q <= W'(s1_q.limb_a[H-1:0]) * W'(s1_q.limb_b[W-1:H]);
      pp_hl_q <= W'(s1_q.limb_a[W-1:H]) * W'(s1_q.limb_b[H-1:0]);
      pp_hh_q <= W'(s1_q.limb_a[W-1:H]) * W'(s1_q.limb_b[W-1:H]);
      s3_q    <= s2_q;
      prod_q  <= prod_d;
    end
  end

  assign prod_d = {{W{1'b0}}, pp_ll_q}
                + {{H{1'b0}}, pp_lh_q, {H{1'b0}}}
                + {{H{1'b0}}, pp_hl_q, {H{1'b0}}}
                + {pp_hh_q, {W{1'b0}}};

  logic         cin;
  logic [W:0]   sum_add, dif_sub, sum_mul;
  logic [W-1:0] rc_new;

  always_comb begin
    cin     = rc_q != '0;
    sum_add = {1'b0, s3_q.limb_a} + {1'b0, s3_q.limb_b} + (W+1)'(cin);
    dif_sub = {1'b0, s3_q.limb_a} - {1'b0, s3_q.limb_b} - (W+1)'(cin);
    sum_mul = {1'b0, prod_q[W-1:0]} + {1'b0, rc_q};
    ver_d   = ver_q;
    r0      = '0;
    r1      = '0;
    two     = 1'b0;
    rc_new  = rc_q;
    case (s3_q.operation)
      lsba_pkg::OP_ADD: begin
        rc_new         = W'(sum_add[W]);
        r0.result_limb = sum_add[W-1:0];
      end
      lsba_pkg::OP_SUB: begin
        rc_new         = W'(dif_sub[W]);
        r0.result_limb = dif_sub[W-1:0];
        r0.underflow   = s3_q.last_limb && dif_sub[W];
      end
      lsba_pkg::OP_MUL: begin
        rc_new         = prod_q[2*W-1:W] + W'(sum_mul[W]);
        r0.result_limb = sum_mul[W-1:0];
      end
      default: begin
        if (s3_q.limb_a > s3_q.limb_b) begin
          ver_d = 1'b1;
        end else if (s3_q.limb_a < s3_q.limb_b) begin
          ver_d = 1'b0;
        end
        r0.greater_or_equal = s3_q.last_limb && ver_d;
      end
    endcase
    two = s3_q.last_limb && (rc_new != '0) &&
          (s3_q.operation == lsba_pkg::OP_ADD || s3_q.operation == lsba_pkg::OP_MUL);
    r0.end_of_number = s3_q.last_limb && !two;
    r1.result_limb   = rc_new;
    r1.end_of_number = 1'b1;
    rc_d = rc_new;
    if (s3_q.last_limb) begin
      rc_d  = '0;
      ver_d = 1'b1;
    end
    n_wr = commit ? (two ? 2'd2 : 2'd1) : 2'd0;
    cnt_d = cnt_q + CntW'(n_wr) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= '0;
      ver_q <= 1'b1;
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (commit) begin
        rc_q  <= rc_d;
        ver_q <= ver_d;
      end
      wp_q  <= wp_q + PtrW'(n_wr);
      rp_q  <= rp_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      fifo_q[wp_q] <= r0;
      if (two) begin
        fifo_q[wp_q + PtrW'(1)] <= r1;
      end
    end
  end

endmodule

@@ sv/lsba_checker.sv @@
// Port-level assertions for the limb-serial bignum ALU, bound to the top level.
module lsba_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input lsba_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_ge_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.greater_or_equal |-> out_data_o.end_of_number)
    else $error("compare verdict before end of number");

  a_uf_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.underflow |->
      out_data_o.end_of_number && !out_data_o.greater_or_equal)
    else $error("underflow off the final subtract result");

  a_stall_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind limb_serial_bignum_alu_unit lsba_checker u_lsba_checker (.*);
